>>> rtl/core/mains_synced_led_phase_dimmer_unit_macros.svh
// Assertion macros for the mains-synced LED phase dimmer
`ifndef MAINS_SYNCED_LED_PHASE_DIMMER_UNIT_MACROS_SVH
`define MAINS_SYNCED_LED_PHASE_DIMMER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MSPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mspd: assertion failed");

// next-cycle implication
`define MSPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mspd: assertion failed");

`endif

>>> rtl/core/mspd_pkg.sv
// Shared constants, types and window arithmetic of the phase dimmer
package mspd_pkg;

   localparam int LIGHTS      = 2;
   localparam int COLORS      = 3;
   localparam int CHANNELS    = COLORS * LIGHTS;
   localparam int CH_BITS     = $clog2(CHANNELS);
   localparam int CNT_BITS    = $clog2(CHANNELS + 1);
   localparam int LEVELS      = 256;
   localparam int LEVEL_BITS  = $clog2(LEVELS);
   localparam int TIME_BITS   = 16;
   localparam int LEVEL_SHIFT = $clog2(2 * LEVELS);
   localparam int PROD_BITS   = TIME_BITS + LEVEL_BITS;

   // colour position inside a light
   localparam int COL_RED   = 0;
   localparam int COL_GREEN = 1;
   localparam int COL_BLUE  = 2;

   // period check: average = (19*old + new) / 20, tolerance old/16
   localparam int AVG_OLD_WEIGHT = 19;
   localparam int SUM_BITS       = TIME_BITS + 5;
   localparam int DIV_SHIFT      = 2;
   localparam int DIV_ODD        = 5;
   localparam int QUO_BITS       = SUM_BITS - DIV_SHIFT;
   localparam int RECIP_SHIFT    = QUO_BITS + 1;
   localparam int RECIP_BITS     = RECIP_SHIFT;
   localparam longint RECIP      = (64'd1 << RECIP_SHIFT) / DIV_ODD;
   localparam int MULT_BITS      = QUO_BITS + RECIP_BITS;
   localparam int TOL_SHIFT      = 4;

   typedef enum logic [1:0] {
      OP_EDGE   = 2'd0,
      OP_TICK   = 2'd1,
      OP_BRIGHT = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [TIME_BITS-1:0]  now;
      logic                  light;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
   } req_item_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] first_rise;
      logic [TIME_BITS-1:0] first_fall;
      logic [TIME_BITS-1:0] second_rise;
      logic [TIME_BITS-1:0] second_fall;
   } window_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      window_type            win;
   } chan_entry_type;

   typedef struct packed {
      logic done;
      logic accept;
   } chk_res_type;

   // windows from the registered product period*level
   function automatic window_type calc_windows(input logic [PROD_BITS-1:0] prod,
                                               input logic [TIME_BITS-1:0] period,
                                               input logic                 odd);
      logic [TIME_BITS-1:0] duty;
      logic [TIME_BITS-1:0] half;
      logic [TIME_BITS:0]   diff;
      logic [TIME_BITS-1:0] r1;
      logic [TIME_BITS-1:0] f1;
      window_type           w;
      duty = TIME_BITS'(prod >> LEVEL_SHIFT);
      half = period >> 1;
      // borrow lands in the top bit, as a wide unsigned difference would
      diff = {1'b0, half} - {1'b0, duty};
      r1 = diff[TIME_BITS:1];
      f1 = r1 + duty + TIME_BITS'(odd);
      w.first_rise  = r1;
      w.first_fall  = f1;
      w.second_rise = half + r1;
      w.second_fall = half + f1;
      return w;
   endfunction

endpackage

>>> rtl/core/mspd_if.sv
// Request and response stream interfaces of the phase dimmer
interface mspd_req_if;
   import mspd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            operation;
   logic [TIME_BITS-1:0]  now;
   logic                  light;
   logic [LEVEL_BITS-1:0] red;
   logic [LEVEL_BITS-1:0] green;
   logic [LEVEL_BITS-1:0] blue;

   modport source (output valid, operation, now, light, red, green, blue, input ready);
   modport sink   (input valid, operation, now, light, red, green, blue, output ready);
endinterface

interface mspd_rsp_if;
   import mspd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHANNELS-1:0]  led_on;
   logic [TIME_BITS-1:0] period;
   logic                 period_accepted;

   modport source (output valid, led_on, period, period_accepted, input ready);
   modport sink   (input valid, led_on, period, period_accepted, output ready);
endinterface

>>> rtl/core/mspd_period_check.sv
// Registered mains period plausibility check against tolerance and running average
module mspd_period_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [mspd_pkg::TIME_BITS-1:0] meas,
   input  logic [mspd_pkg::TIME_BITS-1:0] prev,
   output mspd_pkg::chk_res_type         res
);
   import mspd_pkg::*;

   logic                  go_d_ff, go_d_in;
   logic                  done_ff, done_in;
   logic                  accept_ff, accept_in;
   logic [TIME_BITS-1:0]  meas_ff, prev_ff;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [MULT_BITS-1:0]  mult_ff, mult_in;

   logic [SUM_BITS-1:0]   sum;
   logic [QUO_BITS-1:0]   q0;
   logic [QUO_BITS+2:0]   five_q;
   logic [QUO_BITS+2:0]   rem;
   logic [TIME_BITS:0]    avg;
   logic [TIME_BITS:0]    m_ext, p_ext;
   logic [TIME_BITS:0]    diff_mp, diff_ma, diff_pa;

   // stage 1: weighted sum, divide by 4, multiply by reciprocal of 5
   always_comb begin
      sum = SUM_BITS'(meas) + SUM_BITS'(prev) * SUM_BITS'(AVG_OLD_WEIGHT);
      quo_in = sum[SUM_BITS-1:DIV_SHIFT];
      mult_in = MULT_BITS'(quo_in) * MULT_BITS'(RECIP);
      go_d_in = go;
   end

   // stage 2: correct the estimate by one, then compare distances
   always_comb begin
      q0 = mult_ff[MULT_BITS-1:RECIP_SHIFT];
      five_q = {1'b0, q0, 2'b00} + (QUO_BITS+3)'(q0);
      rem = {3'b000, quo_ff} - five_q;
      avg = (TIME_BITS+1)'(q0) + (TIME_BITS+1)'(rem >= (QUO_BITS+3)'(DIV_ODD));
      m_ext = {1'b0, meas_ff};
      p_ext = {1'b0, prev_ff};
      diff_mp = (m_ext > p_ext) ? m_ext - p_ext : p_ext - m_ext;
      diff_ma = (m_ext > avg) ? m_ext - avg : avg - m_ext;
      diff_pa = (p_ext > avg) ? p_ext - avg : avg - p_ext;
      accept_in = (prev_ff == '0) || (diff_mp < (p_ext >> TOL_SHIFT)) || (diff_ma < diff_pa);
      done_in = go_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_d_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         go_d_ff <= go_d_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         meas_ff <= meas;
         prev_ff <= prev;
         quo_ff  <= quo_in;
         mult_ff <= mult_in;
      end
      accept_ff <= accept_in;
   end

   assign res.done   = done_ff;
   assign res.accept = accept_ff;

endmodule

>>> rtl/core/mains_synced_led_phase_dimmer_unit.sv
// One item is in work and one buffered; the next starts once the current one has posted
// its response. A tick or brightness item sweeps its channels, a later mains edge runs the
// period check and sweeps all channels if the period is accepted, other items go straight
// to the response. The window memory is swept one channel per cycle.
// Reset (synchronous, active high) clears period, edge time, on mask and all channel
// entries through per-entry valid bits; the block is ready the cycle after reset.
module mains_synced_led_phase_dimmer_unit (
   input logic        clock,
   input logic        reset,
   mspd_req_if.sink   req_bus,
   mspd_rsp_if.source rsp_bus
);
   import mspd_pkg::*;

   `include "mains_synced_led_phase_dimmer_unit_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic                  buf_vld_ff, buf_vld_in;
   req_item_type          buf_item_ff, buf_item_in;
   req_item_type          cur_item_ff, cur_item_in;
   logic [TIME_BITS-1:0]  period_ff, period_in;
   logic [TIME_BITS-1:0]  last_edge_ff, last_edge_in;
   logic                  seen_ff, seen_in;
   logic [CHANNELS-1:0]   on_mask_ff, on_mask_in;
   logic [CHANNELS-1:0]   mask_acc_ff, mask_acc_in;
   logic                  acc_ff, acc_in;
   logic [TIME_BITS-1:0]  delta_ff, delta_in;
   logic                  chk_go_ff, chk_go_in;
   logic [CNT_BITS-1:0]   iss_ff, iss_in;
   logic [CNT_BITS-1:0]   end_ff, end_in;
   logic [CNT_BITS-1:0]   base_ff, base_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [CH_BITS-1:0]    s1_ch_ff, s1_ch_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic [CH_BITS-1:0]    s2_ch_ff, s2_ch_in;
   logic [PROD_BITS-1:0]  s2_prod_ff, s2_prod_in;
   logic [LEVEL_BITS-1:0] s2_level_ff, s2_level_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [CHANNELS-1:0]   rsp_mask_ff, rsp_mask_in;
   logic [TIME_BITS-1:0]  rsp_period_ff, rsp_period_in;
   logic                  rsp_acc_ff, rsp_acc_in;

   // channel memory, entries valid once written
   chan_entry_type        chan_mem [CHANNELS];
   logic [CHANNELS-1:0]   chan_vld_ff, chan_vld_in;
   chan_entry_type        rd_data_ff;
   logic                  rd_vld_ff;
   logic                  mem_re, mem_we;
   logic [CH_BITS-1:0]    rd_addr;
   chan_entry_type        wr_entry;

   logic                  engine_take;
   logic                  req_xfer;
   chan_entry_type        entry;
   logic [LEVEL_BITS-1:0] s1_level;
   logic [CH_BITS-1:0]    s1_col;
   logic                  s1_on;
   chk_res_type           chk_res;

   mspd_period_check u_check (
      .clock (clock),
      .reset (reset),
      .go    (chk_go_ff),
      .meas  (delta_ff),
      .prev  (period_ff),
      .res   (chk_res)
   );

   assign engine_take   = (state_ff == ST_IDLE) && buf_vld_ff;
   assign req_bus.ready = !buf_vld_ff || engine_take;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rd_addr       = iss_ff[CH_BITS-1:0];

   // phase compare of the entry just read
   always_comb begin
      entry  = rd_vld_ff ? rd_data_ff : '0;
      s1_col = s1_ch_ff - base_ff[CH_BITS-1:0];
      if (delta_ff < entry.win.first_rise) begin
         s1_on = 1'b0;
      end else if (delta_ff < entry.win.first_fall) begin
         s1_on = 1'b1;
      end else if (delta_ff < entry.win.second_rise) begin
         s1_on = 1'b0;
      end else if (delta_ff < entry.win.second_fall) begin
         s1_on = 1'b1;
      end else begin
         s1_on = 1'b0;
      end
      if (op_type'(cur_item_ff.operation) == OP_BRIGHT) begin
         if (s1_col == CH_BITS'(COL_RED)) begin
            s1_level = cur_item_ff.red;
         end else if (s1_col == CH_BITS'(COL_GREEN)) begin
            s1_level = cur_item_ff.green;
         end else begin
            s1_level = cur_item_ff.blue;
         end
      end else begin
         s1_level = entry.level;
      end
      wr_entry.level = s2_level_ff;
      wr_entry.win   = calc_windows(s2_prod_ff, period_ff, s2_level_ff[0]);
   end

   always_comb begin
      state_in      = state_ff;
      buf_vld_in    = buf_vld_ff;
      buf_item_in   = buf_item_ff;
      cur_item_in   = cur_item_ff;
      period_in     = period_ff;
      last_edge_in  = last_edge_ff;
      seen_in       = seen_ff;
      on_mask_in    = on_mask_ff;
      mask_acc_in   = mask_acc_ff;
      acc_in        = acc_ff;
      delta_in      = delta_ff;
      chk_go_in     = 1'b0;
      iss_in        = iss_ff;
      end_in        = end_ff;
      base_in       = base_ff;
      s1_vld_in     = 1'b0;
      s1_ch_in      = s1_ch_ff;
      s2_vld_in     = 1'b0;
      s2_ch_in      = s1_ch_ff;
      s2_prod_in    = PROD_BITS'(period_ff) * PROD_BITS'(s1_level);
      s2_level_in   = s1_level;
      rsp_vld_in    = rsp_vld_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_period_in = rsp_period_ff;
      rsp_acc_in    = rsp_acc_ff;
      chan_vld_in   = chan_vld_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;

      if (req_xfer) begin
         buf_vld_in            = 1'b1;
         buf_item_in.operation = req_bus.operation;
         buf_item_in.now       = req_bus.now;
         buf_item_in.light     = req_bus.light;
         buf_item_in.red       = req_bus.red;
         buf_item_in.green     = req_bus.green;
         buf_item_in.blue      = req_bus.blue;
      end else if (engine_take) begin
         buf_vld_in = 1'b0;
      end

      if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (buf_vld_ff) begin
               cur_item_in = buf_item_ff;
               acc_in      = 1'b0;
               delta_in    = buf_item_ff.now - last_edge_ff;
               mask_acc_in = '0;
               case (op_type'(buf_item_ff.operation))
                  OP_EDGE: begin
                     last_edge_in = buf_item_ff.now;
                     if (seen_ff) begin
                        chk_go_in = 1'b1;
                        state_in  = ST_CHECK;
                     end else begin
                        seen_in  = 1'b1;
                        state_in = ST_FINISH;
                     end
                  end
                  OP_TICK: begin
                     iss_in   = '0;
                     end_in   = CNT_BITS'(CHANNELS);
                     base_in  = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_BRIGHT: begin
                     if (int'(buf_item_ff.light) < LIGHTS) begin
                        base_in  = CNT_BITS'(COLORS * int'(buf_item_ff.light));
                        iss_in   = CNT_BITS'(COLORS * int'(buf_item_ff.light));
                        end_in   = CNT_BITS'(COLORS * int'(buf_item_ff.light) + COLORS);
                        state_in = ST_SWEEP;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (chk_res.done) begin
               if (chk_res.accept) begin
                  period_in = delta_ff;
                  acc_in    = 1'b1;
                  iss_in    = '0;
                  end_in    = CNT_BITS'(CHANNELS);
                  base_in   = '0;
                  state_in  = ST_SWEEP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SWEEP: begin
            if (iss_ff != end_ff) begin
               mem_re    = 1'b1;
               s1_vld_in = 1'b1;
               s1_ch_in  = rd_addr;
               iss_in    = iss_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               if (op_type'(cur_item_ff.operation) == OP_TICK) begin
                  on_mask_in = mask_acc_ff;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_mask_in   = on_mask_ff;
               rsp_period_in = period_ff;
               rsp_acc_in    = acc_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read-data stage: tick builds the mask, others feed the multiplier
      if (s1_vld_ff) begin
         if (op_type'(cur_item_ff.operation) == OP_TICK) begin
            mask_acc_in[s1_ch_ff] = s1_on;
         end else begin
            s2_vld_in = 1'b1;
         end
      end

      // write-back stage
      if (s2_vld_ff) begin
         mem_we                = 1'b1;
         chan_vld_in[s2_ch_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         buf_vld_ff    <= 1'b0;
         period_ff     <= '0;
         last_edge_ff  <= '0;
         seen_ff       <= 1'b0;
         on_mask_ff    <= '0;
         chk_go_ff     <= 1'b0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         chan_vld_ff   <= '0;
         iss_ff        <= '0;
         end_ff        <= '0;
         base_ff       <= '0;
         acc_ff        <= 1'b0;
         rsp_mask_ff   <= '0;
         rsp_period_ff <= '0;
         rsp_acc_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         buf_vld_ff    <= buf_vld_in;
         period_ff     <= period_in;
         last_edge_ff  <= last_edge_in;
         seen_ff       <= seen_in;
         on_mask_ff    <= on_mask_in;
         chk_go_ff     <= chk_go_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         chan_vld_ff   <= chan_vld_in;
         iss_ff        <= iss_in;
         end_ff        <= end_in;
         base_ff       <= base_in;
         acc_ff        <= acc_in;
         rsp_mask_ff   <= rsp_mask_in;
         rsp_period_ff <= rsp_period_in;
         rsp_acc_ff    <= rsp_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_item_ff <= buf_item_in;
      cur_item_ff <= cur_item_in;
      mask_acc_ff <= mask_acc_in;
      delta_ff    <= delta_in;
      s1_ch_ff    <= s1_ch_in;
      s2_ch_ff    <= s2_ch_in;
      s2_prod_ff  <= s2_prod_in;
      s2_level_ff <= s2_level_in;
   end

   // single read port, single write port, registered read
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= chan_mem[rd_addr];
         rd_vld_ff  <= chan_vld_ff[rd_addr];
      end
      if (mem_we) begin
         chan_mem[s2_ch_ff] <= wr_entry;
      end
   end

   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.led_on          = rsp_mask_ff;
   assign rsp_bus.period          = rsp_period_ff;
   assign rsp_bus.period_accepted = rsp_acc_ff;

   `MSPD_ASSERT_SAME(mem_wr_in_sweep_a, mem_we, state_ff == ST_SWEEP)
   `MSPD_ASSERT_SAME(no_wr_on_tick_a, s2_vld_ff, cur_item_ff.operation != OP_TICK)
   `MSPD_ASSERT_NEXT(chk_wait_a, chk_go_ff, state_ff == ST_CHECK && !chk_res.done)
   `MSPD_ASSERT_SAME(rsp_from_finish_a, $rose(rsp_vld_ff), $past(state_ff) == ST_FINISH)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench of the mains-synced LED phase dimmer: directed table, then random traffic
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mspd_pkg::*;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int RAND_ITEMS   = 1750;
   localparam int IDLE_PCT     = 19;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PLAN_ROWS    = 23;

   typedef struct packed {
      logic [CHANNELS-1:0]  led_on;
      logic [TIME_BITS-1:0] period;
      logic                 accepted;
   } lamp_rsp_type;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      lamp_rsp_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   mspd_req_if req_bus ();
   mspd_rsp_if rsp_bus ();

   mains_synced_led_phase_dimmer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // dimmer image kept by the testbench
   logic [TIME_BITS-1:0]  cur_period;
   logic [TIME_BITS-1:0]  edge_stamp;
   logic                  edge_known;
   logic [LEVEL_BITS-1:0] chan_level [CHANNELS];
   logic [TIME_BITS-1:0]  rise_a [CHANNELS];
   logic [TIME_BITS-1:0]  fall_a [CHANNELS];
   logic [TIME_BITS-1:0]  rise_b [CHANNELS];
   logic [TIME_BITS-1:0]  fall_b [CHANNELS];
   logic [CHANNELS-1:0]   lamp_mask;

   lamp_rsp_type awaited_rsp [$];
   int mismatches = 0;
   int checked    = 0;
   int n_taken    = 0;
   int n_lit      = 0;
   int op_count [4] = '{default: 0};
   int goal       = 250;
   logic calm     = 1'b0;

   // directed rows; only the first few carry a hand-written expectation
   plan_row_type plan [PLAN_ROWS] = '{
      '{'{OP_TICK,    16'd0,    1'b0, 8'd0,   8'd0,   8'd0  }, 1'b1, '{6'd0, 16'd0,   1'b0}},
      '{'{OP_UNKNOWN, 16'hFFFF, 1'b1, 8'hFF,  8'hFF,  8'hFF }, 1'b1, '{6'd0, 16'd0,   1'b0}},
      '{'{OP_EDGE,    16'd100,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b1, '{6'd0, 16'd0,   1'b0}},
      '{'{OP_EDGE,    16'd350,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b1, '{6'd0, 16'd250, 1'b1}},
      '{'{OP_BRIGHT,  16'd0,    1'b0, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{'{OP_BRIGHT,  16'd0,    1'b1, 8'd1,   8'd128, 8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd350,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd474,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd475,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd599,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd600,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd412,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_EDGE,    16'd610,  1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_EDGE,    16'd1610, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_EDGE,    16'd1869, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_BRIGHT,  16'd0,    1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_BRIGHT,  16'd0,    1'b1, 8'd255, 8'd0,   8'd255}, 1'b0, '0},
      '{'{OP_TICK,    16'd1868, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_EDGE,    16'd1868, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_UNKNOWN, 16'd0,    1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_BRIGHT,  16'd0,    1'b1, 8'd255, 8'd0,   8'd255}, 1'b0, '0},
      '{'{OP_TICK,    16'd1997, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0},
      '{'{OP_TICK,    16'd2126, 1'b0, 8'd0,   8'd0,   8'd0  }, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned spread(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // centred pulse: rise at (P/2 - duty)/2, odd levels one tick longer
   function automatic void place_windows(int ch);
      logic [PROD_BITS-1:0] prod;
      logic [TIME_BITS-1:0] half;
      logic [TIME_BITS-1:0] duty;
      logic [TIME_BITS:0]   room;
      prod = PROD_BITS'(cur_period) * PROD_BITS'(chan_level[ch]);
      duty = TIME_BITS'(prod / (2 * LEVELS));
      half = cur_period >> 1;
      room = (TIME_BITS + 1)'(half) - (TIME_BITS + 1)'(duty);
      rise_a[ch] = room[TIME_BITS:1];
      fall_a[ch] = rise_a[ch] + duty + TIME_BITS'(chan_level[ch][0]);
      rise_b[ch] = half + rise_a[ch];
      fall_b[ch] = half + fall_a[ch];
   endfunction

   function automatic lamp_rsp_type advance_dimmer(req_item_type it);
      logic [TIME_BITS-1:0]  gap;
      logic [TIME_BITS-1:0]  place;
      longint unsigned       w;
      longint unsigned       d;
      longint unsigned       avg;
      logic                  took;
      logic                  lit;
      logic [CHANNELS-1:0]   mask;
      logic [LEVEL_BITS-1:0] lv [COLORS];
      int                    base;
      took = 1'b0;
      case (it.operation)
         OP_EDGE: begin
            if (edge_known) begin
               gap = it.now - edge_stamp;
               w = cur_period;
               d = gap;
               avg = (AVG_OLD_WEIGHT * w + d) / (AVG_OLD_WEIGHT + 1);
               if (w == 0 || spread(d, w) < w / (1 << TOL_SHIFT) ||
                   spread(d, avg) < spread(w, avg)) begin
                  cur_period = gap;
                  for (int ch = 0; ch < CHANNELS; ch++) place_windows(ch);
                  took = 1'b1;
                  n_taken++;
               end
            end else begin
               edge_known = 1'b1;
            end
            edge_stamp = it.now;
         end
         OP_TICK: begin
            place = it.now - edge_stamp;
            mask = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               if (place < rise_a[ch]) lit = 1'b0;
               else if (place < fall_a[ch]) lit = 1'b1;
               else if (place < rise_b[ch]) lit = 1'b0;
               else if (place < fall_b[ch]) lit = 1'b1;
               else lit = 1'b0;
               mask[ch] = lit;
            end
            lamp_mask = mask;
         end
         OP_BRIGHT: begin
            // a 1-bit light and 8-bit levels are always in range
            base = int'(it.light) * COLORS;
            lv[COL_RED]   = it.red;
            lv[COL_GREEN] = it.green;
            lv[COL_BLUE]  = it.blue;
            for (int c = 0; c < COLORS; c++) begin
               if (chan_level[base + c] != lv[c]) begin
                  chan_level[base + c] = lv[c];
                  place_windows(base + c);
               end
            end
         end
         default: ;
      endcase
      return '{lamp_mask, cur_period, took};
   endfunction

   function automatic logic [LEVEL_BITS-1:0] pick_level(logic [LEVEL_BITS-1:0] cur);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEVEL_BITS'(LEVELS - 1);
         2: return cur;
         default: return LEVEL_BITS'($urandom);
      endcase
   endfunction

   // mostly ticks around the windows, plus edges that steer the period toward goal
   function automatic req_item_type make_item();
      req_item_type         it;
      int                   w;
      int                   tol;
      int                   d;
      int                   span;
      int                   pick;
      int                   ch;
      int                   base;
      logic [TIME_BITS-1:0] mark;
      it = req_item_type'({$urandom, $urandom});
      w = cur_period;
      tol = w / (1 << TOL_SHIFT);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         it.operation = OP_UNKNOWN;
      end else if (pick < 23) begin
         it.operation = OP_EDGE;
         pick = $urandom_range(0, 99);
         if (pick < 8) d = $urandom_range(0, 65535);
         else if (w == 0) d = goal;
         else if (goal > w + tol && tol >= 2) d = w + tol - 1;
         else if (goal > w + tol) d = w - 1; // too short to widen: fall to zero first
         else if (goal < w - tol) d = (tol >= 2) ? w - tol + 1 : w - 1;
         else if (pick < 20) d = $urandom_range(0, 1) ? w + tol : w - tol;
         else begin
            span = (tol > 0) ? tol - 1 : 0;
            d = w - span + int'($urandom_range(0, 2 * span));
         end
         it.now = edge_stamp + TIME_BITS'(d);
      end else if (pick < 38) begin
         it.operation = OP_BRIGHT;
         base = int'(it.light) * COLORS;
         it.red   = pick_level(chan_level[base + COL_RED]);
         it.green = pick_level(chan_level[base + COL_GREEN]);
         it.blue  = pick_level(chan_level[base + COL_BLUE]);
      end else begin
         it.operation = OP_TICK;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            d = $urandom_range(0, w + w / 8 + 2);
         end else if (pick < 80) begin
            ch = $urandom_range(0, CHANNELS - 1);
            case ($urandom_range(0, 3))
               0: mark = rise_a[ch];
               1: mark = fall_a[ch];
               2: mark = rise_b[ch];
               default: mark = fall_b[ch];
            endcase
            d = int'(mark) + int'($urandom_range(0, 2)) - 1;
         end else begin
            d = $urandom_range(0, 65535);
         end
         it.now = edge_stamp + TIME_BITS'(d);
      end
      return it;
   endfunction

   task automatic report(string what);
      mismatches++;
      if (mismatches <= 40) $display("ERROR %0t ns: %s", $realtime, what);
   endtask

   task automatic send_item(req_item_type it, logic typed, lamp_rsp_type want);
      lamp_rsp_type guess;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= it.operation;
      req_bus.now       <= it.now;
      req_bus.light     <= it.light;
      req_bus.red       <= it.red;
      req_bus.green     <= it.green;
      req_bus.blue      <= it.blue;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      guess = advance_dimmer(it);
      awaited_rsp.push_back(typed ? want : guess);
      op_count[it.operation]++;
      if (it.operation == OP_TICK && guess.led_on != '0) n_lit++;
   endtask

   task automatic sender_idle();
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // result side: check every transfer, stall at random
   initial begin
      lamp_rsp_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            checked++;
            if (awaited_rsp.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_bus.led_on !== want.led_on)
                  report($sformatf("led_on %h, expected %h", rsp_bus.led_on, want.led_on));
               if (rsp_bus.period !== want.period)
                  report($sformatf("period %0d, expected %0d", rsp_bus.period, want.period));
               if (rsp_bus.period_accepted !== want.accepted)
                  report($sformatf("period_accepted %b, expected %b",
                                   rsp_bus.period_accepted, want.accepted));
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("mains_synced_led_phase_dimmer_unit test failed");
      $finish;
   end

   initial begin
      int seg_end;
      int pick;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_EDGE;
      req_bus.now       = '0;
      req_bus.light     = 1'b0;
      req_bus.red       = '0;
      req_bus.green     = '0;
      req_bus.blue      = '0;
      cur_period = '0;
      edge_stamp = '0;
      edge_known = 1'b0;
      lamp_mask  = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         chan_level[ch] = '0;
         rise_a[ch] = '0;
         fall_a[ch] = '0;
         rise_b[ch] = '0;
         fall_b[ch] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         sender_idle();
         send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
      drain();

      seg_end = 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == seg_end) begin
            // new period target; let the block empty out first
            pick = $urandom_range(0, 19);
            if (pick < 10) goal = $urandom_range(200, 320);
            else if (pick < 13) goal = $urandom_range(1, 40);
            else if (pick < 15) goal = 0;
            else if (pick < 18) goal = $urandom_range(30000, 65535);
            else goal = $urandom_range(41, 30000);
            seg_end += $urandom_range(150, 350);
            drain();
         end
         calm = (i >= 700 && i < 1000);
         sender_idle();
         send_item(make_item(), 1'b0, '0);
      end
      calm = 1'b0;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d mains edges (%0d periods taken), %0d ticks (%0d lit), %0d level sets,",
               op_count[OP_EDGE], n_taken, op_count[OP_TICK], n_lit, op_count[OP_BRIGHT]);
      $display("%0d unknown operations; %0d results checked, %0d mismatches",
               op_count[OP_UNKNOWN], checked, mismatches);
      if (mismatches == 0 && awaited_rsp.size() == 0)
         $display("mains_synced_led_phase_dimmer_unit test passed");
      else
         $display("mains_synced_led_phase_dimmer_unit test failed");
      $finish;
   end

endmodule
